// ===== hw/rtl/dats_pkg.sv =====
// ----------------------------------------------------------------------------
// dats_pkg
// Shared types and constants for the disk access time statistics unit.
// ----------------------------------------------------------------------------
package dats_pkg;

  // Disk geometry.
  localparam int TRACKS  = 1024;
  localparam int SECTORS = 30;

  // Field widths.
  localparam int TRACK_W  = 10;
  localparam int SECTOR_W = 5;
  localparam int TIME_W   = 32;
  localparam int SVC_W    = 24;
  localparam int SUM_W    = 48;
  localparam int COST_W   = 8;

  // Widths wide enough to hold the geometry counts themselves.
  localparam int TRK_CMP_W = 17;
  localparam int SEC_CMP_W = 11;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 392;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_SEEK_COST     = 2'd0,
    REG_SECTOR_COST   = 2'd1,
    REG_TRANSFER_COST = 2'd2,
    REG_NONE          = 2'd3
  } dats_reg_t;

  localparam logic [COST_W-1:0] SEEK_COST_RST     = 8'd30;
  localparam logic [COST_W-1:0] SECTOR_COST_RST   = 8'd1;
  localparam logic [COST_W-1:0] TRANSFER_COST_RST = 8'd1;

  // Per-request timing figures.
  typedef struct packed {
    logic [SVC_W-1:0]  service;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] in_system;
  } dats_timing_t;

  // Running statistics.
  typedef struct packed {
    logic [SUM_W-1:0]  sum_wait;
    logic [SUM_W-1:0]  sum_service;
    logic [TIME_W-1:0] max_in_system;
    logic [TIME_W-1:0] min_in_system;
    logic [TIME_W-1:0] max_wait;
    logic [TIME_W-1:0] min_wait;
    logic [SVC_W-1:0]  max_service;
    logic [SVC_W-1:0]  min_service;
  } dats_stats_t;

endpackage

// ===== hw/rtl/disk_access_time_stats_unit.sv =====
// ----------------------------------------------------------------------------
// disk_access_time_stats_unit
// Disk request timing: service, wait, completion and time in system per
// request, with running sums and extremes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  in_       slave      track, sector, arrival_time
//  out_      master     timing figures and running statistics
//  cfg_      APB slave  seek_cost, sector_cost, transfer_cost
//
// One word is accepted per cycle while the result side is not stalled; its result
// is offered after the input register, timing register and result register.
// The head position and previous completion loop back through the timing
// stage, the statistics through the result stage.
// Reset clears all valid flags and statistics and loads the default costs.
// Each stage has its own enable, so bubbles close up behind a stalled result.
// ----------------------------------------------------------------------------
module disk_access_time_stats_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // track [9:0], sector [14:10], arrival_time [46:15], zero [47]
  input  logic [dats_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // service_time, wait_time, completion_time, time_in_system, sum_wait,
  // sum_service, max_in_system, min_in_system, max_wait, min_wait,
  // max_service, min_service
  output logic [dats_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dats_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dats_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dats_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import dats_pkg::*;

  localparam logic [TRK_CMP_W-1:0] TRACKS_LIM  = TRK_CMP_W'(TRACKS);
  localparam logic [SEC_CMP_W-1:0] SECTORS_LIM = SEC_CMP_W'(SECTORS);
  localparam logic [TRACK_W-1:0]   TRACK_TOP   = TRACK_W'(TRACKS - 1);
  localparam logic [SECTOR_W-1:0]  SECTOR_TOP  = SECTOR_W'(SECTORS - 1);
  localparam logic [SEC_CMP_W-1:0] SECTORS_ADD = SEC_CMP_W'(SECTORS);

  // Configuration registers.
  logic [COST_W-1:0] seek_cost_r;
  logic [COST_W-1:0] sector_cost_r;
  logic [COST_W-1:0] transfer_cost_r;
  dats_reg_t         cfg_idx;
  logic              cfg_wr;

  assign cfg_idx    = dats_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_cost_r     <= SEEK_COST_RST;
      sector_cost_r   <= SECTOR_COST_RST;
      transfer_cost_r <= TRANSFER_COST_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SEEK_COST:     seek_cost_r     <= cfg_pwdata[COST_W-1:0];
        REG_SECTOR_COST:   sector_cost_r   <= cfg_pwdata[COST_W-1:0];
        REG_TRANSFER_COST: transfer_cost_r <= cfg_pwdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEEK_COST:     cfg_prdata = {{(CFG_DATA_W-COST_W){1'b0}}, seek_cost_r};
      REG_SECTOR_COST:   cfg_prdata = {{(CFG_DATA_W-COST_W){1'b0}}, sector_cost_r};
      REG_TRANSFER_COST: cfg_prdata = {{(CFG_DATA_W-COST_W){1'b0}}, transfer_cost_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // Stage enables: each stage loads when empty or when its successor loads.
  logic out_v_r, s1_v_r, s0_v_r;
  logic out_en, s1_en, s0_en;

  assign out_en    = !out_v_r || out_tready;
  assign s1_en     = !s1_v_r || out_en;
  assign s0_en     = !s0_v_r || s1_en;
  assign in_tready = s0_en;

  // Input register.
  logic [TRACK_W-1:0]  s0_trk_r;
  logic [SECTOR_W-1:0] s0_sec_r;
  logic [TIME_W-1:0]   s0_arr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en && in_tvalid) begin
      s0_trk_r <= in_tdata[9:0];
      s0_sec_r <= in_tdata[14:10];
      s0_arr_r <= in_tdata[46:15];
    end
  end

  // Head and time state.
  logic [TRACK_W-1:0]  head_track_r;
  logic [SECTOR_W-1:0] head_sector_r;
  logic [TIME_W-1:0]   last_comp_r;
  logic                seen_first_r;

  logic [TRACK_W-1:0]    trk;
  logic [SECTOR_W-1:0]   sec;
  logic [TRACK_W-1:0]    tdist;
  logic [SEC_CMP_W-1:0]  rdist;
  logic [SEC_CMP_W-1:0]  sec_w;
  logic [SEC_CMP_W-1:0]  head_w;
  logic [COST_W+TRACK_W-1:0]   seek_part;
  logic [COST_W+SEC_CMP_W-1:0] rot_part;
  logic [SVC_W:0]        svc_sum;
  logic [SVC_W-1:0]      service;
  logic [SECTOR_W-1:0]   next_sector;
  logic [TIME_W-1:0]     start;
  logic [TIME_W:0]       comp_sum;
  logic [TIME_W:0]       insys_sum;
  dats_timing_t          timing_nxt;

  always_comb begin
    trk = ({{(TRK_CMP_W-TRACK_W){1'b0}}, s0_trk_r} >= TRACKS_LIM) ? TRACK_TOP : s0_trk_r;
    sec = ({{(SEC_CMP_W-SECTOR_W){1'b0}}, s0_sec_r} >= SECTORS_LIM) ? SECTOR_TOP : s0_sec_r;

    tdist  = (trk > head_track_r) ? trk - head_track_r : head_track_r - trk;
    sec_w  = {{(SEC_CMP_W-SECTOR_W){1'b0}}, sec};
    head_w = {{(SEC_CMP_W-SECTOR_W){1'b0}}, head_sector_r};
    // Rotation is always forward, wrapping past the last sector.
    rdist  = (sec >= head_sector_r) ? sec_w - head_w : sec_w + SECTORS_ADD - head_w;

    seek_part = {{TRACK_W{1'b0}}, seek_cost_r} * {{COST_W{1'b0}}, tdist};
    rot_part  = {{SEC_CMP_W{1'b0}}, sector_cost_r} * {{COST_W{1'b0}}, rdist};
    svc_sum   = (SVC_W+1)'(seek_part) + (SVC_W+1)'(rot_part)
              + (SVC_W+1)'(transfer_cost_r);
    service   = svc_sum[SVC_W] ? {SVC_W{1'b1}} : svc_sum[SVC_W-1:0];

    next_sector = (sec == SECTOR_TOP) ? '0 : sec + SECTOR_W'(1);

    if (!seen_first_r) begin
      start = s0_arr_r;
    end else begin
      start = (last_comp_r > s0_arr_r) ? last_comp_r : s0_arr_r;
    end

    timing_nxt.service   = service;
    timing_nxt.wait_time = start - s0_arr_r;
    comp_sum  = {1'b0, start} + {{(TIME_W+1-SVC_W){1'b0}}, service};
    insys_sum = {1'b0, timing_nxt.wait_time} + {{(TIME_W+1-SVC_W){1'b0}}, service};
    timing_nxt.completion = comp_sum[TIME_W] ? {TIME_W{1'b1}} : comp_sum[TIME_W-1:0];
    timing_nxt.in_system  = insys_sum[TIME_W] ? {TIME_W{1'b1}} : insys_sum[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_track_r  <= '0;
      head_sector_r <= '0;
      last_comp_r   <= '0;
      seen_first_r  <= 1'b0;
    end else if (s1_en && s0_v_r) begin
      head_track_r  <= trk;
      head_sector_r <= next_sector;
      last_comp_r   <= timing_nxt.completion;
      seen_first_r  <= 1'b1;
    end
  end

  // Timing register.
  dats_timing_t s1_timing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && s0_v_r) begin
      s1_timing_r <= timing_nxt;
    end
  end

  // Result register; the statistics registers double as its second half.
  dats_timing_t out_timing_r;
  dats_stats_t  stats;
  logic         stats_upd;

  assign stats_upd = out_en && s1_v_r;

  dats_stats u_stats (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (stats_upd),
    .timing (s1_timing_r),
    .stats  (stats)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stats_upd) begin
      out_timing_r <= s1_timing_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {stats.min_service, stats.max_service,
                       stats.min_wait, stats.max_wait,
                       stats.min_in_system, stats.max_in_system,
                       stats.sum_service, stats.sum_wait,
                       out_timing_r.in_system, out_timing_r.completion,
                       out_timing_r.wait_time, out_timing_r.service};

endmodule

// ===== hw/rtl/dats_stats.sv =====
// ----------------------------------------------------------------------------
// dats_stats
// Running saturating sums and extremes of wait, service and time in system.
// ----------------------------------------------------------------------------
module dats_stats (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  dats_pkg::dats_timing_t timing,
  output dats_pkg::dats_stats_t  stats
);
  import dats_pkg::*;

  dats_stats_t stats_r;
  dats_stats_t stats_nxt;

  logic [SUM_W:0] wsum;
  logic [SUM_W:0] ssum;

  always_comb begin
    wsum = {1'b0, stats_r.sum_wait} + {{(SUM_W+1-TIME_W){1'b0}}, timing.wait_time};
    ssum = {1'b0, stats_r.sum_service} + {{(SUM_W+1-SVC_W){1'b0}}, timing.service};

    stats_nxt = stats_r;
    stats_nxt.sum_wait    = wsum[SUM_W] ? {SUM_W{1'b1}} : wsum[SUM_W-1:0];
    stats_nxt.sum_service = ssum[SUM_W] ? {SUM_W{1'b1}} : ssum[SUM_W-1:0];
    if (timing.in_system > stats_r.max_in_system) begin
      stats_nxt.max_in_system = timing.in_system;
    end
    if (timing.in_system < stats_r.min_in_system) begin
      stats_nxt.min_in_system = timing.in_system;
    end
    if (timing.wait_time > stats_r.max_wait) begin
      stats_nxt.max_wait = timing.wait_time;
    end
    if (timing.wait_time < stats_r.min_wait) begin
      stats_nxt.min_wait = timing.wait_time;
    end
    if (timing.service > stats_r.max_service) begin
      stats_nxt.max_service = timing.service;
    end
    if (timing.service < stats_r.min_service) begin
      stats_nxt.min_service = timing.service;
    end
  end

  // The minima start at all ones so that the first request seeds them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r.sum_wait      <= '0;
      stats_r.sum_service   <= '0;
      stats_r.max_in_system <= '0;
      stats_r.min_in_system <= '1;
      stats_r.max_wait      <= '0;
      stats_r.min_wait      <= '1;
      stats_r.max_service   <= '0;
      stats_r.min_service   <= '1;
    end else if (upd) begin
      stats_r <= stats_nxt;
    end
  end

  assign stats = stats_r;

endmodule

// ===== hw/rtl/dats_checker.sv =====
// ----------------------------------------------------------------------------
// dats_checker
// Port-level checks on the disk access time statistics unit.
// ----------------------------------------------------------------------------
module dats_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dats_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import dats_pkg::*;

  // A result held back by the sink must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Nothing is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Once a request has been seen, the service extremes bracket its service time.
  a_service_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[391:368] <= out_tdata[23:0]) &&
                   (out_tdata[23:0] <= out_tdata[367:344]))
    else $error("service time outside its extremes");

  // Time in system covers the wait, and the wait lies within its extremes.
  a_wait_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[119:88] >= out_tdata[55:24]) &&
                   (out_tdata[343:312] <= out_tdata[55:24]) &&
                   (out_tdata[55:24] <= out_tdata[311:280]))
    else $error("wait time inconsistent");

endmodule

bind disk_access_time_stats_unit dats_checker u_dats_checker (.*);
